// ----- design/pli_pkg.sv -----
// Shared types and constants for the leaky-integral PID block.
package pli_pkg;

    localparam int MEAS_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = MEAS_W + 1;
    localparam int DERIV_W = ERR_W + 1;
    localparam int INTEG_W = ERR_W + 1;
    localparam int PROD_PW = GAIN_W + ERR_W;
    localparam int PROD_W  = GAIN_W + DERIV_W;
    localparam int CORR_W  = 35;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P  = 3'd0,
        CFG_GAIN_I  = 3'd1,
        CFG_GAIN_D  = 3'd2,
        CFG_REVERSE = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
    } t_gains;

    // Error, derivative and updated integral of one item
    typedef struct packed {
        logic [ERR_W-1:0]   error;
        logic [DERIV_W-1:0] deriv;
        logic [INTEG_W-1:0] integ;
    } t_terms;

    // Stage load strobes from the pipeline control
    typedef struct packed {
        logic load_terms;
        logic load_prod;
        logic load_sum;
    } t_pipe_ctl;

endpackage

// ----- design/pli_front.sv -----
// Error stage: error, derivative and leaky integral, with the controller state.
module pli_front
    import pli_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  logic              i_reverse,
    input  logic [MEAS_W-1:0] i_measured,
    input  logic [MEAS_W-1:0] i_setpoint,
    output t_terms            o_terms
);

    logic signed [ERR_W-1:0]   r_last_error;
    logic signed [INTEG_W-1:0] r_leaky_sum;
    t_terms                    r_terms;

    logic signed [ERR_W-1:0]     diff;
    logic signed [ERR_W-1:0]     err;
    logic signed [DERIV_W-1:0]   deriv;
    logic signed [INTEG_W:0]     sum2;
    logic signed [INTEG_W:0]     sum2_adj;
    logic signed [INTEG_W-1:0]   n_leaky_sum;

    // Form error and derivative
    always_comb begin
        diff  = $signed({i_setpoint[MEAS_W-1], i_setpoint})
              - $signed({i_measured[MEAS_W-1], i_measured});
        err   = i_reverse ? -diff : diff;
        deriv = $signed({err[ERR_W-1], err})
              - $signed({r_last_error[ERR_W-1], r_last_error});
    end

    // Halve old sum plus twice the error, truncating toward zero
    always_comb begin
        sum2        = $signed({r_leaky_sum[INTEG_W-1], r_leaky_sum})
                    + $signed({err[ERR_W-1], err, 1'b0});
        sum2_adj    = sum2 + $signed({{INTEG_W{1'b0}}, sum2[INTEG_W] & sum2[0]});
        n_leaky_sum = sum2_adj[INTEG_W:1];
    end

    // Update state on transfer into this stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_leaky_sum  <= '0;
        end else if (i_ctl.load_terms) begin
            r_last_error <= err;
            r_leaky_sum  <= n_leaky_sum;
        end
    end

    // Hold the terms for the multiply stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_terms) begin
            r_terms.error <= err;
            r_terms.deriv <= deriv;
            r_terms.integ <= n_leaky_sum;
        end
    end

    assign o_terms = r_terms;

    // State moves only with a transfer into the stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.load_terms |=> $stable(r_last_error) && $stable(r_leaky_sum))
        else $error("controller state changed without a transfer");

    // Stored error and registered terms agree after a load
    a_terms_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_terms |=> (r_terms.error == r_last_error)
                          && (r_terms.integ == r_leaky_sum))
        else $error("terms register and state disagree");

    // Leaky integral stays within its proven range
    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_leaky_sum <= 18'sd131070) && (r_leaky_sum >= -18'sd131070))
        else $error("leaky integral out of range");

endmodule

// ----- design/pli_mac.sv -----
// Multiply stage and sum stage of the weighted PID correction.
module pli_mac
    import pli_pkg::*;
(
    input  logic              i_clk,
    input  t_pipe_ctl         i_ctl,
    input  t_gains            i_gains,
    input  t_terms            i_terms,
    output logic [CORR_W-1:0] o_correction
);

    logic signed [PROD_PW-1:0] r_prod_p;
    logic signed [PROD_W-1:0]  r_prod_i;
    logic signed [PROD_W-1:0]  r_prod_d;
    logic signed [CORR_W-1:0]  r_sum;
    logic signed [CORR_W-1:0]  n_sum;

    // Multiply each term by its gain
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_prod_p <= $signed(i_gains.gain_p) * $signed(i_terms.error);
            r_prod_i <= $signed(i_gains.gain_i) * $signed(i_terms.integ);
            r_prod_d <= $signed(i_gains.gain_d) * $signed(i_terms.deriv);
        end
    end

    // Add the three products
    always_comb begin
        n_sum = $signed({{(CORR_W-PROD_PW){r_prod_p[PROD_PW-1]}}, r_prod_p})
              + $signed({{(CORR_W-PROD_W){r_prod_i[PROD_W-1]}}, r_prod_i})
              + $signed({{(CORR_W-PROD_W){r_prod_d[PROD_W-1]}}, r_prod_d});
    end

    // Hold the result until the output transfer
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_correction = r_sum;

endmodule

// ----- design/pid_leaky_integral_top.sv -----
// Top level of the PID controller with leaky integrator.
//
// Each transfer of (measured, setpoint) yields one correction =
// gain_p*error + gain_d*derivative + gain_i*integral, signed with 8 fraction
// bits (Q8.8 gains). The block takes one item every cycle. An item passes four
// registers (input register, error stage, multiply stage, sum register); it
// enters the input register at its transfer edge, and output valid rises when
// it reaches the sum register. The rate is set by the error stage, where the
// stored error and leaky integral are read and rewritten in the same cycle.
// The stages stall together when the output is not taken. Gains and the
// direction bit are written through the configuration channel, which is
// always ready; write it only while no item is in flight.
module pid_leaky_integral_top
    import pli_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [MEAS_W-1:0]    i_measured,
    input  logic [MEAS_W-1:0]    i_setpoint,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CORR_W-1:0]    o_correction,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    t_gains            r_gains;
    logic              r_reverse;
    logic              r_in_valid;
    logic              r_terms_valid;
    logic              r_prod_valid;
    logic              r_out_valid;
    logic [MEAS_W-1:0] r_measured;
    logic [MEAS_W-1:0] r_setpoint;

    logic      en_out;
    logic      en_prod;
    logic      en_terms;
    logic      en_in;
    t_pipe_ctl ctl;
    t_terms    terms;

    // Configuration writes; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains   <= '0;
            r_reverse <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:  r_gains.gain_p <= i_cfg_data;
                CFG_GAIN_I:  r_gains.gain_i <= i_cfg_data;
                CFG_GAIN_D:  r_gains.gain_d <= i_cfg_data;
                CFG_REVERSE: r_reverse      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Stage enables: a stage advances when empty or when its successor advances
    always_comb begin
        en_out         = !r_out_valid || i_out_ready;
        en_prod        = !r_prod_valid || en_out;
        en_terms       = !r_terms_valid || en_prod;
        en_in          = !r_in_valid || en_terms;
        ctl.load_terms = r_in_valid && en_terms;
        ctl.load_prod  = r_terms_valid && en_prod;
        ctl.load_sum   = r_prod_valid && en_out;
    end

    assign o_in_ready  = en_in;
    assign o_out_valid = r_out_valid;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_terms_valid <= 1'b0;
            r_prod_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (en_in)    r_in_valid    <= i_in_valid;
            if (en_terms) r_terms_valid <= r_in_valid;
            if (en_prod)  r_prod_valid  <= r_terms_valid;
            if (en_out)   r_out_valid   <= r_prod_valid;
        end
    end

    // Capture the input payload on transfer
    always_ff @(posedge i_clk) begin
        if (i_in_valid && en_in) begin
            r_measured <= i_measured;
            r_setpoint <= i_setpoint;
        end
    end

    pli_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_reverse  (r_reverse),
        .i_measured (r_measured),
        .i_setpoint (r_setpoint),
        .o_terms    (terms)
    );

    pli_mac u_mac (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_gains      (r_gains),
        .i_terms      (terms),
        .o_correction (o_correction)
    );

    // An empty output register never blocks the input
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // An item moves into the sum register only from a full product stage
    a_sum_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_out && !r_prod_valid) |=> !r_out_valid)
        else $error("output valid without a product in flight");

endmodule

// ----- verif/pid_leaky_integral_checker.sv -----
// Checker for the leaky-integral PID block: predicts each correction and compares.
`timescale 1ns / 1ps

module pid_leaky_integral_checker
    import pli_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [MEAS_W-1:0]    i_measured,
    input  logic [MEAS_W-1:0]    i_setpoint,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [CORR_W-1:0]    i_correction,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the gains, direction and error history
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic                      negate_err;
    logic signed [ERR_W-1:0]   prev_err;
    logic signed [INTEG_W-1:0] leak_acc;

    logic [CORR_W-1:0] pending_corrections[$];
    logic [CORR_W-1:0] want;
    int                miscompares = 0;

    // Work out one correction and advance the stored error and integral
    function automatic logic [CORR_W-1:0] next_correction(input logic [MEAS_W-1:0] meas,
                                                          input logic [MEAS_W-1:0] target);
        logic signed [ERR_W-1:0]   err_now;
        logic signed [DERIV_W-1:0] slope;
        int                        twice_sum;
        longint                    acc;

        err_now = $signed({target[MEAS_W-1], target}) - $signed({meas[MEAS_W-1], meas});
        if (negate_err) begin
            err_now = -err_now;
        end
        slope = err_now - prev_err;

        // Halve the sum of old integral and twice the error, rounding toward zero
        twice_sum = int'(leak_acc) + 2 * int'(err_now);
        leak_acc  = twice_sum / 2;
        prev_err  = err_now;

        acc = longint'(kp) * longint'(err_now)
            + longint'(kd) * longint'(slope)
            + longint'(ki) * longint'(leak_acc);
        return acc[CORR_W-1:0];
    endfunction

    // Count a failure, print only the first few
    task automatic note_failure(input string what, input logic [CORR_W-1:0] exp_val,
                                input logic [CORR_W-1:0] got_val);
        if (miscompares < REPORT_LIMIT) begin
            $display("%0t: %s: expected %h, got %h", $time, what, exp_val, got_val);
        end
        miscompares++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            negate_err = 1'b0;
            prev_err   = '0;
            leak_acc   = '0;
            pending_corrections.delete();
        end else begin
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GAIN_P:  kp = i_cfg_data;
                    CFG_GAIN_I:  ki = i_cfg_data;
                    CFG_GAIN_D:  kd = i_cfg_data;
                    CFG_REVERSE: negate_err = i_cfg_data[0];
                    default: ;
                endcase
            end

            // Compare each result transfer with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (pending_corrections.size() == 0) begin
                    note_failure("correction with nothing outstanding", '0, i_correction);
                end else begin
                    want = pending_corrections.pop_front();
                    if (want !== i_correction) begin
                        note_failure("correction mismatch", want, i_correction);
                    end
                end
            end

            // Predict on each input transfer
            if (i_in_valid && i_in_ready) begin
                pending_corrections.push_back(next_correction(i_measured, i_setpoint));
            end
        end
        o_pending    <= pending_corrections.size();
        o_fail_count <= miscompares;
    end

endmodule

// ----- verif/pid_leaky_integral_top_tb.sv -----
// Testbench top for the leaky-integral PID block: stimulus, reset and verdict.
`timescale 1ns / 1ps

module pid_leaky_integral_top_tb;
    import pli_pkg::*;

    localparam int NUM_PHASES       = 10;
    localparam int ITEMS_PER_PHASE  = 120;
    localparam int BURST_ITEMS      = 40;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES     = 8;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [MEAS_W-1:0]    measured  = '0;
    logic [MEAS_W-1:0]    setpoint  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CORR_W-1:0]    correction;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_data  = '0;

    int fail_count;
    int pending;

    // Idle controls shared between the two sides
    int gap_pct   = 0;
    int stall_pct = 0;
    bit long_hold = 1'b0;

    // Tracking-loop state for well-formed random items
    int walk_meas   = 0;
    int walk_target = 0;

    always #5 clk = ~clk;

    pid_leaky_integral_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_measured   (measured),
        .i_setpoint   (setpoint),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_correction (correction),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    pid_leaky_integral_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_measured   (measured),
        .i_setpoint   (setpoint),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_correction (correction),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one item and hold it until the transfer; valid stays high afterwards
    task automatic send_item(input int meas, input int target);
        in_valid <= 1'b1;
        measured <= meas[MEAS_W-1:0];
        setpoint <= target[MEAS_W-1:0];
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid for a random burst now and then
    task automatic maybe_gap();
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every outstanding correction
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write all registers, sometimes with a stray write to an unused index
    task automatic load_setting(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                                input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] dir_word);
        write_reg(CFG_GAIN_P, p);
        write_reg(CFG_GAIN_I, i);
        write_reg(CFG_GAIN_D, d);
        write_reg(CFG_REVERSE, dir_word);
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_REVERSE) + 1, (1 << CFG_IDX_W) - 1)),
                      GAIN_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // Random item: mostly a loop tracking its target, some full-range and extreme noise
    task automatic send_next();
        int pick;
        int meas;
        int target;

        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            meas   = $signed(MEAS_W'($urandom));
            target = $signed(MEAS_W'($urandom));
        end else if (pick < 40) begin
            case ($urandom_range(0, 4))
                0: meas = -32768;
                1: meas = 32767;
                2: meas = 0;
                3: meas = -1;
                default: meas = 1;
            endcase
            case ($urandom_range(0, 4))
                0: target = -32768;
                1: target = 32767;
                2: target = 0;
                3: target = -1;
                default: target = 1;
            endcase
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                walk_target = $signed(MEAS_W'($urandom));
            end
            walk_meas = walk_meas + (walk_target - walk_meas) / 4
                      + int'($urandom_range(0, 200)) - 100;
            if (walk_meas > 32767) begin
                walk_meas = 32767;
            end else if (walk_meas < -32768) begin
                walk_meas = -32768;
            end
            meas   = walk_meas;
            target = walk_target;
        end
        send_item(meas, target);
    endtask

    // Result side: random stalls, long clean stretches, one long hold-off on request
    initial begin : result_side
        int span;
        forever begin
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                out_ready <= 1'b0;
                span = $urandom_range(1, 12);
                repeat (span) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 16);
                repeat (span) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        bit tail;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unity gains, extremes of the error and the odd-sum halving
        load_setting(16'h0100, 16'h0100, 16'h0100, 16'h0000);
        send_item(0, 0);
        send_item(-32768, 32767);
        send_item(32767, -32768);
        send_item(0, 3);
        send_item(0, -5);
        send_item(0, -3);
        send_item(0, 5);
        send_item(1, 1);
        send_item(-1, 0);
        settle();

        // Directed: most negative and most positive gains, reversed direction,
        // integral driven toward its top and back
        load_setting(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
        repeat (12) send_item(32767, -32768);
        send_item(-32768, 32767);
        send_item(-32768, 32767);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            tail = (ph >= NUM_PHASES - 2);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 20;
                default: stall_pct = 45;
            endcase
            if (tail) begin
                gap_pct   = 0;
                stall_pct = 0;
            end

            case (ph)
                0: load_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
                1: load_setting(16'h8000, 16'h8000, 16'h8000, 16'h0001);
                2: load_setting(16'h0100, 16'h0000, 16'h0000, GAIN_W'($urandom));
                default: load_setting(GAIN_W'($urandom), GAIN_W'($urandom),
                                      GAIN_W'($urandom), GAIN_W'($urandom));
            endcase

            // Hold off the result side while items keep coming, so the input stalls
            if (ph == 3) begin
                long_hold = 1'b1;
                repeat (BURST_ITEMS) send_next();
                settle();
            end

            repeat (ITEMS_PER_PHASE) begin
                maybe_gap();
                send_next();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- pid_leaky_integral_top.f -----
design/pli_pkg.sv
design/pli_front.sv
design/pli_mac.sv
design/pid_leaky_integral_top.sv
verif/pid_leaky_integral_checker.sv
verif/pid_leaky_integral_top_tb.sv
